// File: rtl/row_coverage_interval_merge_core_defines.svh
// ----------------------------------------------------------------------------
// Row coverage interval merge - assertion macros
// Shared property forms for the checker of the merge core.
// ----------------------------------------------------------------------------
`ifndef ROW_COVERAGE_INTERVAL_MERGE_CORE_DEFINES_SVH
`define ROW_COVERAGE_INTERVAL_MERGE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RCIM_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcim check failed");

// next-cycle implication, disabled in reset
`define RCIM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcim check failed");

`endif

// File: rtl/rcim_pkg.sv
// ----------------------------------------------------------------------------
// rcim_pkg
// Widths, word layouts, types and sequencer states of the interval merge core.
// ----------------------------------------------------------------------------
package rcim_pkg;

    localparam int MAX_INTERVALS  = 32;
    localparam int COORD_BITS     = 26;
    localparam int REACH_BITS     = COORD_BITS - 1;
    localparam int SPAN_BITS      = COORD_BITS + 1;
    localparam int ENTRY_BITS     = 2 * SPAN_BITS;
    localparam int IDX_BITS       = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_BITS       = $clog2(MAX_INTERVALS + 1);
    localparam int COUNT_OUT_BITS = 6;

    localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_INTERVALS);

    // input word layout
    localparam int X_LSB        = 0;
    localparam int Y_LSB        = X_LSB + COORD_BITS;
    localparam int REACH_LSB    = Y_LSB + COORD_BITS;
    localparam int ROW_LSB      = REACH_LSB + REACH_BITS;
    localparam int IN_USED_BITS = ROW_LSB + COORD_BITS;
    localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

    // output word layout
    localparam int LO_LSB        = 0;
    localparam int HI_LSB        = LO_LSB + SPAN_BITS;
    localparam int CNT_LSB       = HI_LSB + SPAN_BITS;
    localparam int GAP_LSB       = CNT_LSB + COUNT_OUT_BITS;
    localparam int OUT_USED_BITS = GAP_LSB + SPAN_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    // output tuser bits
    localparam int UB_COVERS   = 0;
    localparam int UB_GAPVALID = 1;
    localparam int UB_OVERFLOW = 2;
    localparam int OUT_USER_BITS = 3;

    typedef struct packed {
        logic signed [SPAN_BITS-1:0] hi;
        logic signed [SPAN_BITS-1:0] lo;
    } t_ival;

    typedef struct packed {
        logic                         clear;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [REACH_BITS-1:0] reach;
        logic signed [COORD_BITS-1:0] row;
    } t_req;

    typedef struct packed {
        logic                            covers;
        logic signed [SPAN_BITS-1:0]     span_lo;
        logic signed [SPAN_BITS-1:0]     span_hi;
        logic        [COUNT_OUT_BITS-1:0] count;
        logic                            gap_valid;
        logic signed [SPAN_BITS-1:0]     gap_x;
        logic                            overflow;
    } t_res;

    typedef struct packed {
        logic contained;
        logic touch;
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN_A,
        ST_SPAN_B,
        ST_SPAN_C,
        ST_SCAN,
        ST_FINAL,
        ST_RESULT
    } t_state;

endpackage

// File: rtl/row_coverage_interval_merge_core.sv
// ----------------------------------------------------------------------------
// row_coverage_interval_merge_core
// Cuts the row span of a Manhattan coverage diamond and merges it into a
// stored set of disjoint intervals; reports span, count and first gap.
//
//   channel   dir  tdata                               tuser
//   s_axis    in   x, y, reach, row (104 bits)          clear_row
//   m_axis    out  span_low, span_high, count, gap_x    covers, gap_valid, ovf
//
// When the diamond misses the row, a word goes from SPAN_A through SPAN_B and
// SPAN_C straight to RESULT; otherwise the one compare unit walks the interval
// RAM one entry per cycle and FINAL appends the merged span; a span already
// contained stops the walk early. One word is in work at a time.
// Reset clears the sequencer and the interval count; the RAM is not swept.
// A finished result waits in the engine while the output register is held.
// ----------------------------------------------------------------------------
module row_coverage_interval_merge_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sensor_x, sensor_y, sensor_reach, target_row, zero pad
    input  logic [rcim_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // clear_row
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // span_low, span_high, interval_count, gap_x, zero pad
    output logic [rcim_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    // covers_row, gap_valid, overflow
    output logic [rcim_pkg::OUT_USER_BITS-1:0]  o_m_axis_tuser
);

    localparam int DW = rcim_pkg::OUT_DATA_BITS;

    rcim_pkg::t_req w_req;
    rcim_pkg::t_res w_res;
    logic           w_idle;
    logic           w_res_valid;
    logic           w_out_free;
    logic           w_accept;

    logic                                r_m_valid;
    logic [rcim_pkg::OUT_DATA_BITS-1:0]  r_m_data;
    logic [rcim_pkg::OUT_USER_BITS-1:0]  r_m_user;

    assign w_req.clear = i_s_axis_tuser;
    assign w_req.x     = i_s_axis_tdata[rcim_pkg::X_LSB +: rcim_pkg::COORD_BITS];
    assign w_req.y     = i_s_axis_tdata[rcim_pkg::Y_LSB +: rcim_pkg::COORD_BITS];
    assign w_req.reach = i_s_axis_tdata[rcim_pkg::REACH_LSB +: rcim_pkg::REACH_BITS];
    assign w_req.row   = i_s_axis_tdata[rcim_pkg::ROW_LSB +: rcim_pkg::COORD_BITS];

    assign o_s_axis_tready = w_idle;
    assign w_accept        = i_s_axis_tvalid && w_idle;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;

    rcim_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_req       (w_req),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_free) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_m_data <= DW'({w_res.gap_x, w_res.count, w_res.span_hi, w_res.span_lo});
            r_m_user[rcim_pkg::UB_COVERS]   <= w_res.covers;
            r_m_user[rcim_pkg::UB_GAPVALID] <= w_res.gap_valid;
            r_m_user[rcim_pkg::UB_OVERFLOW] <= w_res.overflow;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

// File: rtl/rcim_ram.sv
// ----------------------------------------------------------------------------
// rcim_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/rcim_cmp.sv
// ----------------------------------------------------------------------------
// rcim_cmp
// Shared compare unit: containment, touch test and widening of the span.
// ----------------------------------------------------------------------------
module rcim_cmp (
    input  rcim_pkg::t_ival i_entry,
    input  rcim_pkg::t_ival i_span,
    input  rcim_pkg::t_ival i_run,
    output rcim_pkg::t_cmp  o_cmp,
    output rcim_pkg::t_ival o_merged
);

    logic signed [rcim_pkg::SPAN_BITS:0] w_run_hi_p1;
    logic signed [rcim_pkg::SPAN_BITS:0] w_run_lo_m1;
    logic signed [rcim_pkg::SPAN_BITS:0] w_elo_ext;
    logic signed [rcim_pkg::SPAN_BITS:0] w_ehi_ext;

    assign w_run_hi_p1 = $signed({i_run.hi[rcim_pkg::SPAN_BITS-1], i_run.hi})
                       + $signed((rcim_pkg::SPAN_BITS+1)'(1));
    assign w_run_lo_m1 = $signed({i_run.lo[rcim_pkg::SPAN_BITS-1], i_run.lo})
                       - $signed((rcim_pkg::SPAN_BITS+1)'(1));
    assign w_elo_ext   = $signed({i_entry.lo[rcim_pkg::SPAN_BITS-1], i_entry.lo});
    assign w_ehi_ext   = $signed({i_entry.hi[rcim_pkg::SPAN_BITS-1], i_entry.hi});

    always_comb begin
        o_cmp.contained = (i_entry.lo <= i_span.lo) && (i_entry.hi >= i_span.hi);
        o_cmp.touch     = (w_elo_ext <= w_run_hi_p1) && (w_ehi_ext >= w_run_lo_m1);
        o_merged.lo     = (i_entry.lo < i_run.lo) ? i_entry.lo : i_run.lo;
        o_merged.hi     = (i_entry.hi > i_run.hi) ? i_entry.hi : i_run.hi;
    end

endmodule

// File: rtl/rcim_engine.sv
// ----------------------------------------------------------------------------
// rcim_engine
// Sequencer: cuts the span from the diamond, walks the interval RAM through
// the shared compare unit, compacts survivors, adds the merged span if room.
// ----------------------------------------------------------------------------
module rcim_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rcim_pkg::t_req  i_req,
    input  logic            i_out_free,
    output logic            o_idle,
    output logic            o_res_valid,
    output rcim_pkg::t_res  o_res
);

    localparam int S  = rcim_pkg::SPAN_BITS;
    localparam int C  = rcim_pkg::COORD_BITS;
    localparam int R  = rcim_pkg::REACH_BITS;
    localparam int IB = rcim_pkg::IDX_BITS;
    localparam int CB = rcim_pkg::CNT_BITS;

    rcim_pkg::t_state r_state, n_state;

    rcim_pkg::t_req   r_req;
    logic [CB-1:0]    r_total;
    logic [S-1:0]     r_dy;
    logic             r_covers;
    logic [R-1:0]     r_xr;
    rcim_pkg::t_ival  r_span;
    rcim_pkg::t_ival  r_run;
    logic [CB-1:0]    r_idx;
    logic [CB-1:0]    r_kept;
    logic             r_ovf;
    rcim_pkg::t_ival  r_sh0;
    rcim_pkg::t_ival  r_sh1;

    logic             w_rd_en;
    logic [IB-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [IB-1:0]    w_wr_addr;
    rcim_pkg::t_ival  w_wr_data;
    logic [rcim_pkg::ENTRY_BITS-1:0] w_rd_data;
    rcim_pkg::t_ival  w_entry;
    rcim_pkg::t_cmp   w_cmp;
    rcim_pkg::t_ival  w_merged;

    logic signed [S-1:0] w_diff;
    logic        [S-1:0] w_abs;
    logic signed [S-1:0] w_xe;
    logic signed [S-1:0] w_xr_ext;
    logic [CB-1:0]       w_idx_next;
    logic                w_room;
    logic                w_gap_valid;

    assign w_entry    = rcim_pkg::t_ival'(w_rd_data);
    assign w_idx_next = r_idx + CB'(1);
    assign w_room     = r_kept < rcim_pkg::MAX_COUNT;

    assign w_diff   = $signed({r_req.row[C-1], r_req.row}) - $signed({r_req.y[C-1], r_req.y});
    assign w_abs    = w_diff[S-1] ? (~w_diff + S'(1)) : w_diff;
    assign w_xe     = $signed({r_req.x[C-1], r_req.x});
    assign w_xr_ext = $signed({{(S-R){1'b0}}, r_xr});

    rcim_ram #(
        .WIDTH (rcim_pkg::ENTRY_BITS),
        .DEPTH (rcim_pkg::MAX_INTERVALS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    rcim_cmp u_cmp (
        .i_entry  (w_entry),
        .i_span   (r_span),
        .i_run    (r_run),
        .o_cmp    (w_cmp),
        .o_merged (w_merged)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcim_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = rcim_pkg::ST_SPAN_A;
                end
            end
            rcim_pkg::ST_SPAN_A: n_state = rcim_pkg::ST_SPAN_B;
            rcim_pkg::ST_SPAN_B: n_state = rcim_pkg::ST_SPAN_C;
            rcim_pkg::ST_SPAN_C: begin
                if (!r_covers) begin
                    n_state = rcim_pkg::ST_RESULT;
                end else if (r_total == '0) begin
                    n_state = rcim_pkg::ST_FINAL;
                end else begin
                    n_state = rcim_pkg::ST_SCAN;
                end
            end
            rcim_pkg::ST_SCAN: begin
                if (w_cmp.contained) begin
                    n_state = rcim_pkg::ST_RESULT;
                end else if (w_idx_next == r_total) begin
                    n_state = rcim_pkg::ST_FINAL;
                end
            end
            rcim_pkg::ST_FINAL: n_state = rcim_pkg::ST_RESULT;
            rcim_pkg::ST_RESULT: begin
                if (i_out_free) begin
                    n_state = rcim_pkg::ST_IDLE;
                end
            end
            default: n_state = rcim_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_kept[IB-1:0];
        w_wr_data   = w_entry;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            rcim_pkg::ST_IDLE:   o_idle = 1'b1;
            rcim_pkg::ST_SPAN_C: w_rd_en = 1'b1;
            rcim_pkg::ST_SCAN: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_idx_next[IB-1:0];
                w_wr_en   = !w_cmp.contained && !w_cmp.touch;
            end
            rcim_pkg::ST_FINAL: begin
                w_wr_en   = w_room;
                w_wr_data = r_run;
            end
            rcim_pkg::ST_RESULT: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcim_pkg::ST_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == rcim_pkg::ST_IDLE && i_start && i_req.clear) begin
                r_total <= '0;
            end
            if (r_state == rcim_pkg::ST_FINAL) begin
                r_total <= w_room ? (r_kept + CB'(1)) : r_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rcim_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_req <= i_req;
                end
            end
            rcim_pkg::ST_SPAN_A: r_dy <= w_abs;
            rcim_pkg::ST_SPAN_B: begin
                r_covers <= r_dy <= {{(S-R){1'b0}}, r_req.reach};
                r_xr     <= r_req.reach - r_dy[R-1:0];
            end
            rcim_pkg::ST_SPAN_C: begin
                r_idx  <= '0;
                r_kept <= '0;
                r_ovf  <= 1'b0;
                if (r_covers) begin
                    r_span.lo <= w_xe - w_xr_ext;
                    r_span.hi <= w_xe + w_xr_ext;
                    r_run.lo  <= w_xe - w_xr_ext;
                    r_run.hi  <= w_xe + w_xr_ext;
                end else begin
                    r_span <= '0;
                    r_run  <= '0;
                end
            end
            rcim_pkg::ST_SCAN: begin
                if (!w_cmp.contained) begin
                    r_idx <= w_idx_next;
                    if (w_cmp.touch) begin
                        r_run <= w_merged;
                    end else begin
                        r_kept <= r_kept + CB'(1);
                    end
                end
            end
            rcim_pkg::ST_FINAL: r_ovf <= !w_room;
            default: ;
        endcase
        if (w_wr_en && w_wr_addr == IB'(0)) begin
            r_sh0 <= w_wr_data;
        end
        if (w_wr_en && w_wr_addr == IB'(1)) begin
            r_sh1 <= w_wr_data;
        end
    end

    assign w_gap_valid = r_total > CB'(1);

    always_comb begin
        o_res.covers    = r_covers;
        o_res.span_lo   = r_span.lo;
        o_res.span_hi   = r_span.hi;
        o_res.count     = rcim_pkg::COUNT_OUT_BITS'(r_total);
        o_res.gap_valid = w_gap_valid;
        o_res.overflow  = r_ovf;
        if (!w_gap_valid) begin
            o_res.gap_x = '0;
        end else if (r_sh0.hi < r_sh1.lo) begin
            o_res.gap_x = r_sh0.hi + S'(1);
        end else begin
            o_res.gap_x = r_sh1.hi + S'(1);
        end
    end

endmodule

// File: rtl/rcim_checker.sv
// ----------------------------------------------------------------------------
// rcim_checker
// Port-level checks of the interval merge core, bound to the top level.
// ----------------------------------------------------------------------------
`include "row_coverage_interval_merge_core_defines.svh"

module rcim_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [rcim_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    input logic [rcim_pkg::OUT_USER_BITS-1:0]  o_m_axis_tuser
);

    localparam int S  = rcim_pkg::SPAN_BITS;
    localparam int CW = rcim_pkg::COUNT_OUT_BITS;

    logic [CW-1:0] w_count;
    logic          w_in_word;
    logic          w_gap_ok;
    logic          w_miss;
    logic          w_miss_ok;
    logic          w_hold;
    logic [rcim_pkg::OUT_DATA_BITS+rcim_pkg::OUT_USER_BITS-1:0] w_out_word;

    assign w_count    = o_m_axis_tdata[rcim_pkg::CNT_LSB +: CW];
    assign w_in_word  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_gap_ok   = o_m_axis_tuser[rcim_pkg::UB_GAPVALID] == (w_count > CW'(1));
    assign w_miss     = o_m_axis_tvalid && !o_m_axis_tuser[rcim_pkg::UB_COVERS];
    assign w_miss_ok  = (o_m_axis_tdata[rcim_pkg::LO_LSB +: S] == '0)
                     && (o_m_axis_tdata[rcim_pkg::HI_LSB +: S] == '0)
                     && !o_m_axis_tuser[rcim_pkg::UB_OVERFLOW];
    assign w_hold     = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_word = {o_m_axis_tuser, o_m_axis_tdata};

    `RCIM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_word, !o_s_axis_tready)

    `RCIM_ASSERT_IMPLIES(a_gap_matches_count, i_clk, i_rst_n, o_m_axis_tvalid, w_gap_ok)

    `RCIM_ASSERT_IMPLIES(a_miss_is_empty, i_clk, i_rst_n, w_miss, w_miss_ok)

    `RCIM_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, w_hold, o_m_axis_tvalid && $stable(w_out_word))

endmodule

bind row_coverage_interval_merge_core rcim_checker u_rcim_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for row_coverage_interval_merge_core. A short table of
// corner words runs first, followed by random runs: sequences that fill the
// interval store to overflow, clustered diamonds near one row, and noise over
// the full coordinate range. Every accepted word is run through a local
// interval merge predictor. Each result word is compared field by field with
// the oldest queued expectation. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB        = rcim_pkg::COORD_BITS;
    localparam int RB        = rcim_pkg::REACH_BITS;
    localparam int SB        = rcim_pkg::SPAN_BITS;
    localparam int NB        = rcim_pkg::COUNT_OUT_BITS;
    localparam int MAXI      = rcim_pkg::MAX_INTERVALS;
    localparam int C_MAX     = (1 << (CB - 1)) - 1;
    localparam int C_MIN     = -(1 << (CB - 1));
    localparam int R_MAX     = (1 << RB) - 1;
    localparam int WORD_GOAL = 650;
    localparam int CALM_FROM = 560;
    localparam int DIR_ROWS  = 17;

    typedef struct packed {
        rcim_pkg::t_req req;
        logic           typed;
        rcim_pkg::t_res res;
    } t_dir_row;

    localparam rcim_pkg::t_res NONE = '0;

    // request: clear, x, y, reach, row
    // typed result: covers, span_lo, span_hi, count, gap_valid, gap_x, overflow
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{0, 0, 0, 0, 1},                1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{1, 0, 0, 0, 0},                1, '{1, 0, 0, 1, 0, 0, 0}},
        '{'{0, 10, 0, 0, 0},               1, '{1, 10, 10, 2, 1, 1, 0}},
        '{'{0, 1, 0, 0, 0},                0, NONE},
        '{'{0, 0, 0, 0, 0},                0, NONE},
        '{'{0, 5, 3, 4, 7},                0, NONE},
        '{'{0, 5, 3, 4, 8},                0, NONE},
        '{'{0, 20, 9, 6, 4},               0, NONE},
        '{'{0, 4, 0, 8, 0},                0, NONE},
        '{'{1, C_MAX, C_MIN, R_MAX, C_MIN}, 0, NONE},
        '{'{0, C_MIN, C_MAX, R_MAX, C_MAX}, 0, NONE},
        '{'{0, C_MIN, C_MIN, R_MAX, C_MAX}, 0, NONE},
        '{'{1, C_MAX, C_MAX, 0, C_MIN},     1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{0, C_MAX, C_MAX, 0, C_MAX},     1, '{1, C_MAX, C_MAX, 1, 0, 0, 0}},
        '{'{0, C_MIN, C_MIN, 0, C_MIN},     1, '{1, C_MIN, C_MIN, 2, 1, C_MIN + 1, 0}},
        '{'{0, -100, 0, R_MAX, 0},          0, NONE},
        '{'{0, -7, -3, 2, -2},              0, NONE}
    };

    logic                               i_clk    = 1'b0;
    logic                               i_rst_n  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [rcim_pkg::IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                               s_tuser  = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [rcim_pkg::OUT_DATA_BITS-1:0] m_tdata;
    logic [rcim_pkg::OUT_USER_BITS-1:0] m_tuser;

    longint         span_lo_store [MAXI];
    longint         span_hi_store [MAXI];
    int             span_total     = 0;
    rcim_pkg::t_res expected_spans [$];
    int             mismatch_count = 0;
    int             result_index   = 0;
    int             word_count     = 0;
    int             stall_left     = 0;
    bit             idle_on        = 1'b0;
    bit             stall_on       = 1'b0;

    row_coverage_interval_merge_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic rcim_pkg::t_res cover_and_merge(input rcim_pkg::t_req r);
        longint         x, y, reach, row, dy, xr, lo, hi, elo, ehi;
        int             kept;
        bit             held;
        rcim_pkg::t_res res;
        x     = longint'(r.x);
        y     = longint'(r.y);
        row   = longint'(r.row);
        reach = longint'({1'b0, r.reach});
        res   = '0;
        if (r.clear) begin
            span_total = 0;
        end
        dy = row - y;
        if (dy < 0) begin
            dy = -dy;
        end
        if (dy <= reach) begin
            xr = reach - dy;
            lo = x - xr;
            hi = x + xr;
            res.covers  = 1'b1;
            res.span_lo = SB'(lo);
            res.span_hi = SB'(hi);
            held = 1'b0;
            for (int i = 0; i < span_total; i++) begin
                if (span_lo_store[i] <= lo && span_hi_store[i] >= hi) begin
                    held = 1'b1;
                end
            end
            if (!held) begin
                kept = 0;
                for (int i = 0; i < span_total; i++) begin
                    elo = span_lo_store[i];
                    ehi = span_hi_store[i];
                    if (elo <= hi + 1 && ehi >= lo - 1) begin
                        if (elo < lo) begin
                            lo = elo;
                        end
                        if (ehi > hi) begin
                            hi = ehi;
                        end
                    end else begin
                        span_lo_store[kept] = elo;
                        span_hi_store[kept] = ehi;
                        kept++;
                    end
                end
                span_total = kept;
                if (span_total >= MAXI) begin
                    res.overflow = 1'b1;
                end else begin
                    span_lo_store[span_total] = lo;
                    span_hi_store[span_total] = hi;
                    span_total++;
                end
            end
        end
        res.count = NB'(span_total);
        if (span_total > 1) begin
            res.gap_valid = 1'b1;
            if (span_hi_store[0] < span_lo_store[1]) begin
                res.gap_x = SB'(span_hi_store[0] + 1);
            end else begin
                res.gap_x = SB'(span_hi_store[1] + 1);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        $display("mismatch at result %0d: %s = %0d, expected %0d",
                 result_index, what, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic send_word(input rcim_pkg::t_req r, input bit typed,
                             input rcim_pkg::t_res given);
        logic [rcim_pkg::IN_DATA_BITS-1:0] w;
        rcim_pkg::t_res                    predicted;
        rcim_pkg::t_res                    queued;
        w = '0;
        w[rcim_pkg::X_LSB +: CB]     = r.x;
        w[rcim_pkg::Y_LSB +: CB]     = r.y;
        w[rcim_pkg::REACH_LSB +: RB] = r.reach;
        w[rcim_pkg::ROW_LSB +: CB]   = r.row;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= r.clear;
        do @(posedge i_clk); while (!s_tready);
        predicted      = cover_and_merge(r);
        queued         = typed ? given : predicted;
        expected_spans = {expected_spans, queued};
        word_count++;
    endtask

    // drain: hold off until every pending result has come back
    task automatic hold_off(input bit drain);
        int n;
        if (drain) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while (expected_spans.size() != 0);
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            n = int'($urandom_range(1, 7));
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        rcim_pkg::t_res got;
        rcim_pkg::t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.covers    = m_tuser[rcim_pkg::UB_COVERS];
            got.span_lo   = m_tdata[rcim_pkg::LO_LSB +: SB];
            got.span_hi   = m_tdata[rcim_pkg::HI_LSB +: SB];
            got.count     = m_tdata[rcim_pkg::CNT_LSB +: NB];
            got.gap_valid = m_tuser[rcim_pkg::UB_GAPVALID];
            got.gap_x     = m_tdata[rcim_pkg::GAP_LSB +: SB];
            got.overflow  = m_tuser[rcim_pkg::UB_OVERFLOW];
            if (expected_spans.size() == 0) begin
                report_mismatch("unexpected word", longint'(1), longint'(0));
            end else begin
                want = expected_spans.pop_front();
                if (got.covers != want.covers)
                    report_mismatch("covers_row", longint'(got.covers), longint'(want.covers));
                if (got.span_lo != want.span_lo)
                    report_mismatch("span_low", longint'(got.span_lo), longint'(want.span_lo));
                if (got.span_hi != want.span_hi)
                    report_mismatch("span_high", longint'(got.span_hi), longint'(want.span_hi));
                if (got.count != want.count)
                    report_mismatch("interval_count", longint'(got.count), longint'(want.count));
                if (got.gap_valid != want.gap_valid)
                    report_mismatch("gap_valid", longint'(got.gap_valid),
                                    longint'(want.gap_valid));
                if (got.gap_x != want.gap_x)
                    report_mismatch("gap_x", longint'(got.gap_x), longint'(want.gap_x));
                if (got.overflow != want.overflow)
                    report_mismatch("overflow", longint'(got.overflow), longint'(want.overflow));
            end
            result_index++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(1, 7)) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        rcim_pkg::t_req r;
        int             mode;
        int             len;
        int             cx;
        int             row;
        int             d;
        bit             drain_now;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on  = 1'b1;
        stall_on = 1'b1;
        foreach (DIRECTED[i]) begin
            hold_off(1'b0);
            send_word(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);
        end
        while (word_count < WORD_GOAL) begin
            mode      = int'($urandom_range(0, 9));
            idle_on   = (word_count < CALM_FROM) && ($urandom_range(0, 3) != 0);
            stall_on  = (word_count < CALM_FROM) && ($urandom_range(0, 3) != 0);
            drain_now = (word_count == DIR_ROWS)
                     || ((word_count < CALM_FROM) && ($urandom_range(0, 2) == 0));
            cx  = int'($urandom_range(0, 2 * C_MAX - 400)) + C_MIN + 200;
            row = int'($urandom_range(0, 2 * C_MAX - 400)) + C_MIN + 200;
            if (mode < 4) begin
                len = int'($urandom_range(30, 50));
            end else if (mode < 8) begin
                len = int'($urandom_range(10, 30));
            end else begin
                len = int'($urandom_range(5, 15));
            end
            for (int k = 0; k < len && word_count < WORD_GOAL; k++) begin
                if (mode < 4) begin
                    // fill: narrow diamonds marching along the row, often enough to overflow
                    d       = int'($urandom_range(0, 2));
                    r.clear = (k == 0);
                    r.x     = CB'(cx + 3 * k);
                    r.y     = CB'(row - d);
                    r.row   = CB'(row);
                    r.reach = RB'(d + (($urandom_range(0, 7) == 0) ? 1 : 0));
                end else if (mode < 8) begin
                    r.clear = ($urandom_range(0, 24) == 0);
                    r.x     = CB'(cx + int'($urandom_range(0, 200)) - 100);
                    r.y     = CB'(row + int'($urandom_range(0, 40)) - 20);
                    r.row   = CB'(row);
                    r.reach = RB'($urandom_range(0, 60));
                end else begin
                    r.clear = ($urandom_range(0, 7) == 0);
                    r.x     = CB'($urandom);
                    r.y     = CB'($urandom);
                    r.reach = RB'($urandom);
                    if ($urandom_range(0, 1) == 1) begin
                        r.row = CB'(int'(r.y) + int'($urandom_range(0, 3)));
                    end else begin
                        r.row = CB'($urandom);
                    end
                end
                hold_off(k == 0 && drain_now);
                send_word(r, 1'b0, NONE);
            end
        end
        idle_on  = 1'b0;
        stall_on = 1'b0;
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/rcim_pkg.sv
rtl/rcim_ram.sv
rtl/rcim_cmp.sv
rtl/rcim_engine.sv
rtl/row_coverage_interval_merge_core.sv
rtl/rcim_checker.sv
tb/testbench.sv
